@@ rtl/asa_pkg.sv @@
// Shared types and constants for the aligned stack allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package asa_pkg;

    localparam int OFS_W  = 13;  // offsets, sizes and capacity
    localparam int ADDR_W = 32;  // absolute addresses
    localparam int PAD_W  = 8;   // one header entry
    localparam int SUM_W  = 15;  // offset + padding + size without overflow
    localparam int ALOG_W = 3;

    // Minimum padding in front of every block, room for the header entry.
    localparam logic [PAD_W-1:0] HEADER_BYTES = 8'd1;

    localparam logic [OFS_W-1:0] CAP_RESET = 13'd4096;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OOM = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic REG_BASE = 1'b0;
    localparam logic REG_CAP  = 1'b1;

    typedef struct packed {
        logic load_item;
        logic mem_read;
        logic commit_alloc;
        logic commit_free;
    } t_dp_cmd;

    typedef struct packed {
        logic item_is_free;
        logic out_free;
    } t_dp_status;

endpackage

@@ rtl/aligned_stack_allocator_core.sv @@
// Top level of the aligned stack allocator: stream ports, APB register file,
// controller and datapath. Uses asa_pkg, asa_ctrl and asa_datapath.
//
// Bump-pointer stack allocator over a region of REGION_BYTES bytes. Each
// input beat is an allocate or a free; each produces exactly one result beat
// carrying a status, the granted address, the bytes in use and the peak
// usage since reset. An allocate is accepted into the item register in the
// idle state; the execute state then does the padding, the add and the
// capacity compare against the current top offset, and as it ends the result
// enters the output register. A free passes through a further state,
// since the stored padding is fetched from the header memory through its
// registered read port before the top offset rewinds. Items are processed one
// at a time because each depends on the offset the previous one left; a new
// beat is accepted while an earlier result still waits in the output
// register, but while the output stays stalled a finished item holds its
// commit and the input stays closed until the output register frees up.
// The header memory holds REGION_BYTES bytes, needs no clearing after reset,
// and entries never written by an allocate read as undefined. Registers:
// base_address at byte address 0, capacity at byte address 4 (reset 4096,
// values above REGION_BYTES act as REGION_BYTES). Write registers only while
// the block is idle.
module aligned_stack_allocator_core #(
    parameter int REGION_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata from bit 0: request_size[12:0], align_log2[15:13], block_address[47:16]
    input  logic [47:0] s_axis_tdata,
    // tuser: kind[0] (0 allocate, 1 free)
    input  logic        s_axis_tuser,

    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata from bit 0: granted_address[31:0], used_bytes[44:32],
    // peak_bytes[57:45], zero fill[63:58]
    output logic [63:0] m_axis_tdata,
    // tuser: status[1:0] (0 ok, 1 out of memory, 2 bad pointer)
    output logic [1:0]  m_axis_tuser,

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import asa_pkg::*;

    logic [ADDR_W-1:0] r_base;
    logic [OFS_W-1:0]  r_cap;
    logic              w_wr;
    logic              w_reg_sel;

    t_dp_cmd           w_cmd;
    t_dp_status        w_stat;

    logic [1:0]        w_status;
    logic [ADDR_W-1:0] w_granted;
    logic [OFS_W-1:0]  w_used;
    logic [OFS_W-1:0]  w_peak;

    // Registers sit on 4-byte boundaries, so bit 2 selects between them.
    assign pready    = 1'b1;
    assign w_reg_sel = paddr[2];
    assign w_wr      = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_cap  <= CAP_RESET;
        end else if (w_wr) begin
            unique case (w_reg_sel)
                REG_BASE: r_base <= pwdata;
                REG_CAP:  r_cap  <= pwdata[OFS_W-1:0];
                default:  r_base <= r_base;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_sel)
            REG_BASE: prdata = r_base;
            REG_CAP:  prdata = 32'(r_cap);
            default:  prdata = '0;
        endcase
    end

    asa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (w_stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    asa_datapath #(
        .REGION_BYTES (REGION_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_base      (r_base),
        .i_cap       (r_cap),
        .i_kind      (s_axis_tuser),
        .i_size      (s_axis_tdata[12:0]),
        .i_alog      (s_axis_tdata[15:13]),
        .i_addr      (s_axis_tdata[47:16]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_status    (w_status),
        .o_granted   (w_granted),
        .o_used      (w_used),
        .o_peak      (w_peak)
    );

    assign m_axis_tdata = {6'd0, w_peak, w_used, w_granted};
    assign m_axis_tuser = w_status;

endmodule

@@ rtl/asa_ctrl.sv @@
// Sequencer of the aligned stack allocator: takes an item, runs it through
// the datapath and hands the result to the output register. Uses asa_pkg.
module asa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  asa_pkg::t_dp_status i_stat,
    output logic               o_in_ready,
    output asa_pkg::t_dp_cmd   o_cmd
);
    import asa_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FREE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state            = r_state;
        o_cmd              = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_item = i_in_valid;
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_stat.item_is_free) begin
                    o_cmd.mem_read = 1'b1;
                    n_state        = S_FREE;
                end else if (i_stat.out_free) begin
                    o_cmd.commit_alloc = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_FREE: begin
                if (i_stat.out_free) begin
                    o_cmd.commit_free = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_commit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.commit_alloc || o_cmd.commit_free) |-> i_stat.out_free)
        else $error("result committed while the output register is occupied");

    a_read_then_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mem_read |=> (r_state == S_FREE))
        else $error("header read not followed by the free step");

    a_commit_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.commit_alloc || o_cmd.commit_free) |=> o_in_ready)
        else $error("controller did not return to idle after a commit");

endmodule

@@ rtl/asa_datapath.sv @@
// Datapath of the aligned stack allocator: item register, top offset and peak,
// the padding header memory and the output register. Uses asa_pkg.
module asa_datapath #(
    parameter int REGION_BYTES = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  asa_pkg::t_dp_cmd            i_cmd,
    output asa_pkg::t_dp_status         o_stat,
    input  logic [asa_pkg::ADDR_W-1:0]  i_base,
    input  logic [asa_pkg::OFS_W-1:0]   i_cap,
    input  logic                        i_kind,
    input  logic [asa_pkg::OFS_W-1:0]   i_size,
    input  logic [asa_pkg::ALOG_W-1:0]  i_alog,
    input  logic [asa_pkg::ADDR_W-1:0]  i_addr,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [1:0]                  o_status,
    output logic [asa_pkg::ADDR_W-1:0]  o_granted,
    output logic [asa_pkg::OFS_W-1:0]   o_used,
    output logic [asa_pkg::OFS_W-1:0]   o_peak
);
    import asa_pkg::*;

    localparam int AW    = $clog2(REGION_BYTES);
    localparam int IDX_W = (AW > OFS_W) ? AW : OFS_W;
    localparam logic [OFS_W-1:0] CAP_LIM =
        (REGION_BYTES >= (1 << OFS_W)) ? {OFS_W{1'b1}} : OFS_W'(REGION_BYTES);

    // Item register.
    logic              r_kind;
    logic [OFS_W-1:0]  r_size;
    logic [ALOG_W-1:0] r_alog;
    logic [ADDR_W-1:0] r_addr;

    // Allocator state.
    logic [OFS_W-1:0]  r_top;
    logic [OFS_W-1:0]  r_peak;

    // Free step registers.
    logic [OFS_W-1:0]  r_rel;
    logic              r_bad_span;
    logic [PAD_W-1:0]  r_rd_pad;

    logic [PAD_W-1:0]  r_mem [REGION_BYTES];

    // Output register.
    logic              r_ovalid;
    logic [1:0]        r_status;
    logic [ADDR_W-1:0] r_granted;
    logic [OFS_W-1:0]  r_used;
    logic [OFS_W-1:0]  r_opeak;

    logic [ADDR_W-1:0] w_cur;
    logic [PAD_W-1:0]  w_tmp;
    logic [PAD_W-1:0]  w_mask;
    logic [PAD_W-1:0]  w_pad;
    logic [SUM_W-1:0]  w_end;
    logic [SUM_W-1:0]  w_hidx;
    logic [OFS_W-1:0]  w_cap_eff;
    logic              w_oom;
    logic [IDX_W-1:0]  w_widx;
    logic [ADDR_W-1:0] w_rel;
    logic              w_bad_span;
    logic [OFS_W-1:0]  w_rel_m1;
    logic [IDX_W-1:0]  w_ridx;
    logic              w_bad_free;

    // Padding: smallest value of at least the header size that aligns cur.
    always_comb begin
        w_cur     = i_base + ADDR_W'(r_top);
        w_tmp     = w_cur[PAD_W-1:0] + HEADER_BYTES;
        w_mask    = (PAD_W'(1) << r_alog) - PAD_W'(1);
        w_pad     = HEADER_BYTES + ((PAD_W'(0) - w_tmp) & w_mask);
        w_end     = SUM_W'(r_top) + SUM_W'(w_pad) + SUM_W'(r_size);
        w_hidx    = SUM_W'(r_top) + SUM_W'(w_pad) - SUM_W'(1);
        w_cap_eff = (i_cap > CAP_LIM) ? CAP_LIM : i_cap;
        w_oom     = (w_end > SUM_W'(w_cap_eff));
        w_widx    = IDX_W'(w_hidx[OFS_W-1:0]);

        w_rel      = r_addr - i_base;
        w_bad_span = (w_rel < ADDR_W'(HEADER_BYTES)) || (w_rel > ADDR_W'(r_top));
        w_rel_m1   = w_rel[OFS_W-1:0] - OFS_W'(1);
        w_ridx     = IDX_W'(w_rel_m1);

        w_bad_free = r_bad_span || (OFS_W'(r_rd_pad) > r_rel);
    end

    assign o_stat.item_is_free = (r_kind == KIND_FREE);
    assign o_stat.out_free     = !r_ovalid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_kind <= i_kind;
            r_size <= i_size;
            r_alog <= i_alog;
            r_addr <= i_addr;
        end
        if (i_cmd.mem_read) begin
            r_rel      <= w_rel[OFS_W-1:0];
            r_bad_span <= w_bad_span;
        end
    end

    // Header memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_alloc && !w_oom) begin
            r_mem[w_widx[AW-1:0]] <= w_pad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_read) begin
            r_rd_pad <= r_mem[w_ridx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top    <= '0;
            r_peak   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.commit_alloc) begin
                r_ovalid <= 1'b1;
                r_opeak  <= r_peak;
                if (w_oom) begin
                    r_status  <= ST_OOM;
                    r_granted <= '0;
                    r_used    <= r_top;
                end else begin
                    r_status  <= ST_OK;
                    r_granted <= w_cur + ADDR_W'(w_pad);
                    r_used    <= w_end[OFS_W-1:0];
                    r_top     <= w_end[OFS_W-1:0];
                    if (w_end[OFS_W-1:0] > r_peak) begin
                        r_peak  <= w_end[OFS_W-1:0];
                        r_opeak <= w_end[OFS_W-1:0];
                    end
                end
            end else if (i_cmd.commit_free) begin
                r_ovalid  <= 1'b1;
                r_opeak   <= r_peak;
                r_granted <= '0;
                if (w_bad_free) begin
                    r_status <= ST_BAD;
                    r_used   <= r_top;
                end else begin
                    r_status <= ST_OK;
                    r_used   <= r_rel - OFS_W'(r_rd_pad);
                    r_top    <= r_rel - OFS_W'(r_rd_pad);
                end
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_status    = r_status;
    assign o_granted   = r_granted;
    assign o_used      = r_used;
    assign o_peak      = r_opeak;

    a_top_below_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= r_peak)
        else $error("top offset above the recorded peak");

    a_peak_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_peak >= $past(r_peak)))
        else $error("peak usage decreased");

    a_grant_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_status != ST_OK)) |-> (r_granted == '0))
        else $error("nonzero address on a failed item");

endmodule

@@ tb/sv/tb_aligned_stack_allocator_core.sv @@
// Self-checking testbench for aligned_stack_allocator_core: directed and random
// allocate/free beats, APB register writes, and random stalls on both streams.
// Depends on asa_pkg and the aligned_stack_allocator_core RTL only.
module tb_aligned_stack_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import asa_pkg::*;

    localparam int REGION = 4096;

    // One request beat as the allocator sees it.
    typedef struct {
        logic              kind;
        logic [OFS_W-1:0]  size;
        logic [ALOG_W-1:0] alog;
        logic [31:0]       addr;
    } t_alloc_req;

    // One result beat.
    typedef struct {
        logic [1:0]       status;
        logic [31:0]      granted;
        logic [OFS_W-1:0] used;
        logic [OFS_W-1:0] peak;
    } t_alloc_resp;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // tdata from bit 0: request_size[12:0], align_log2[15:13], block_address[47:16]
    logic [47:0] s_axis_tdata;
    // tuser: kind[0]
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // tdata from bit 0: granted_address[31:0], used_bytes[44:32], peak_bytes[57:45]
    logic [63:0] m_axis_tdata;
    // tuser: status[1:0]
    logic [1:0]  m_axis_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    aligned_stack_allocator_core #(
        .REGION_BYTES(REGION)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the allocator: registers, top offset, peak and the header
    // bytes. header_valid marks entries some allocate has written, so that no
    // free is ever aimed at a header whose contents are undefined.
    logic [31:0]      model_base;
    logic [OFS_W-1:0] model_cap;
    logic [31:0]      model_top;
    logic [31:0]      model_peak;
    logic [7:0]       header_pad [REGION];
    bit               header_valid [REGION];

    // Results still owed by the block, oldest first.
    t_alloc_resp      pending_outcomes [$];
    // Header-relative offsets (address minus base) of blocks still below the
    // top offset, in ascending order. Well-formed frees are drawn from here.
    logic [31:0]      live_blocks [$];

    int unsigned mismatches = 0;
    bit          sender_idle = 1'b1;
    bit          sink_idle = 1'b1;
    int unsigned hold_request = 0;

    // Gap length, from the shortest of three ranges most of the time and rarely the longest.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return $urandom_range(2, 1);
        if (roll < 95)
            return $urandom_range(8, 3);
        return $urandom_range(60, 20);
    endfunction

    // Smallest padding of at least one header that aligns addr to 2^alog.
    function automatic logic [31:0] align_padding(logic [31:0] addr, logic [ALOG_W-1:0] alog);
        logic [31:0] align;
        logic [31:0] pad;
        logic [31:0] need;
        align = 32'd1 << alog;
        pad = (align - (addr & (align - 32'd1))) & (align - 32'd1);
        if (pad < 32'(HEADER_BYTES)) begin
            need = 32'(HEADER_BYTES) - pad;
            pad = pad + align * ((need + align - 32'd1) >> alog);
        end
        return pad;
    endfunction

    // Advances the shadow state by one accepted beat and returns its result.
    function automatic t_alloc_resp apply_request(t_alloc_req rq);
        t_alloc_resp rs;
        logic [31:0] eff_cap;
        logic [31:0] cur;
        logic [31:0] pad;
        logic [31:0] fin;
        logic [31:0] rel;
        logic [31:0] hidx;
        rs.status = ST_OK;
        rs.granted = 32'd0;
        eff_cap = (32'(model_cap) > REGION) ? REGION : 32'(model_cap);
        if (rq.kind == KIND_ALLOC) begin
            cur = model_base + model_top;
            pad = align_padding(cur, rq.alog);
            fin = model_top + pad + 32'(rq.size);
            if (fin > eff_cap) begin
                rs.status = ST_OOM;
            end else begin
                hidx = model_top + pad - 32'd1;
                if (hidx < REGION) begin
                    header_pad[hidx] = pad[7:0];
                    header_valid[hidx] = 1'b1;
                end
                rs.granted = cur + pad;
                model_top = fin;
                if (model_top > model_peak)
                    model_peak = model_top;
            end
        end else begin
            rel = rq.addr - model_base;
            if (rel < 32'(HEADER_BYTES) || rel > model_top) begin
                rs.status = ST_BAD;
            end else begin
                pad = {24'd0, header_pad[rel - 32'd1]};
                // With a one-byte header every written entry sits at or above its
                // own padding, so the too-large-padding branch stays dormant.
                if (pad > rel)
                    rs.status = ST_BAD;
                else
                    model_top = rel - pad;
            end
        end
        rs.used = model_top[OFS_W-1:0];
        rs.peak = model_peak[OFS_W-1:0];
        return rs;
    endfunction

    // True when a free of addr either fails the span check or lands on a
    // header entry that has been written.
    function automatic bit header_readable(logic [31:0] addr);
        logic [31:0] rel;
        rel = addr - model_base;
        if (rel < 32'(HEADER_BYTES) || rel > model_top)
            return 1'b1;
        return header_valid[rel - 32'd1];
    endfunction

    function automatic t_alloc_req make_req(logic kind, int unsigned size, int unsigned alog,
                                            logic [31:0] addr);
        t_alloc_req rq;
        rq.kind = kind;
        rq.size = OFS_W'(size);
        rq.alog = ALOG_W'(alog);
        rq.addr = addr;
        return rq;
    endfunction

    function automatic logic [OFS_W-1:0] random_size();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return OFS_W'($urandom_range(32));
        if (roll < 85)
            return OFS_W'($urandom_range(256, 33));
        if (roll < 97)
            return OFS_W'($urandom_range(1024, 257));
        if (roll < 99)
            return OFS_W'($urandom_range(4096, 1025));
        return OFS_W'(4096);
    endfunction

    // Mostly allocates and frees of live blocks; the rest are frees at any offset
    // up to just past the top, and fully random beats.
    function automatic t_alloc_req make_random_request();
        t_alloc_req  rq;
        int unsigned roll;
        int unsigned pick;
        rq.kind = KIND_ALLOC;
        rq.size = random_size();
        rq.alog = ALOG_W'($urandom_range(7));
        rq.addr = $urandom();
        roll = $urandom_range(99);
        if (roll < 50) begin
            rq.kind = KIND_ALLOC;
        end else if (roll < 85 && live_blocks.size() != 0) begin
            rq.kind = KIND_FREE;
            if ($urandom_range(2) != 0)
                pick = live_blocks.size() - 1;
            else
                pick = $urandom_range(live_blocks.size() - 1);
            rq.addr = model_base + live_blocks[pick];
        end else if (roll < 93) begin
            rq.kind = KIND_FREE;
            rq.addr = model_base + 32'($urandom_range(model_top + 2));
        end else begin
            rq.kind = 1'($urandom_range(1));
        end
        return rq;
    endfunction

    // Sends one request beat. Called at a falling edge and returns at one. With
    // no gap drawn, tvalid stays high so the next beat follows back to back.
    task automatic send_request(t_alloc_req rq);
        t_alloc_resp rs;
        int unsigned gap;
        // A free must never reach a header that was never written.
        if (rq.kind == KIND_FREE && !header_readable(rq.addr))
            rq.addr = model_base;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rq.addr, rq.alog, rq.size};
        s_axis_tuser  <= rq.kind;
        do @(posedge i_clk); while (!s_axis_tready);
        rs = apply_request(rq);
        pending_outcomes.push_back(rs);
        if (rq.kind == KIND_ALLOC && rs.status == ST_OK)
            live_blocks.push_back(rs.granted - model_base);
        while (live_blocks.size() != 0 && live_blocks[$] > model_top)
            void'(live_blocks.pop_back());
        @(negedge i_clk);
        gap = (sender_idle && $urandom_range(3) == 0) ? pick_gap() : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Stops offering beats and waits for every owed result, then lets the clock
    // run on so that the block is surely idle. Returns at a falling edge.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready. Only done idle.
    task automatic write_register(logic idx, logic [31:0] value);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_BASE)
            model_base = value;
        else
            model_cap = value[OFS_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_random_phase(int unsigned count);
        for (int unsigned n = 0; n < count; n++) begin
            // Re-roll the idling now and then, so some stretches run flat out.
            if (n % 40 == 0) begin
                sender_idle = ($urandom_range(3) != 0);
                sink_idle   = ($urandom_range(3) != 0);
            end
            send_request(make_random_request());
        end
    endtask

    // Reset register values: header-only blocks, alignments, an exact fill,
    // out of memory, bad pointers on both sides of the span, non-top free.
    task automatic test_reset_config();
        send_request(make_req(KIND_ALLOC, 0, 0, 32'd0));
        send_request(make_req(KIND_ALLOC, 5, 3, 32'hFFFF_FFFF));
        send_request(make_req(KIND_ALLOC, 100, 7, 32'd0));
        send_request(make_req(KIND_ALLOC, 4096, 0, 32'd0));
        send_request(make_req(KIND_FREE, 8191, 7, 32'd0));
        send_request(make_req(KIND_FREE, 0, 0, 32'd229));
        // Freeing the middle block also releases the one above it.
        send_request(make_req(KIND_FREE, 0, 0, 32'd8));
        send_request(make_req(KIND_FREE, 0, 0, 32'd1));
        send_request(make_req(KIND_ALLOC, 4095, 0, 32'd0));
        send_request(make_req(KIND_ALLOC, 0, 0, 32'd0));
        send_request(make_req(KIND_FREE, 0, 0, 32'd1));
        send_request(make_req(KIND_FREE, 0, 0, 32'hFFFF_FFFF));
    endtask

    // Zero and one byte of capacity, with the base at the top of the address
    // space so that the granted address wraps to zero.
    task automatic test_capacity_extremes();
        write_register(REG_CAP, 32'd0);
        send_request(make_req(KIND_ALLOC, 0, 0, 32'd0));
        write_register(REG_BASE, 32'hFFFF_FFFF);
        write_register(REG_CAP, 32'd1);
        send_request(make_req(KIND_ALLOC, 0, 0, 32'd0));
        send_request(make_req(KIND_ALLOC, 0, 7, 32'd0));
        send_request(make_req(KIND_FREE, 0, 0, 32'd0));
    endtask

    // Capacity beyond the region acts as the region; base just below a wrap.
    task automatic test_base_wrap();
        write_register(REG_BASE, 32'hFFFF_FF80);
        write_register(REG_CAP, 32'h0000_1FFF);
        send_request(make_req(KIND_ALLOC, 4096, 7, 32'd0));
        send_request(make_req(KIND_ALLOC, 3968, 7, 32'd0));
        send_request(make_req(KIND_ALLOC, 0, 0, 32'd0));
        send_request(make_req(KIND_FREE, 0, 0, 32'd0));
        send_request(make_req(KIND_ALLOC, 17, 6, 32'd0));
        send_request(make_req(KIND_FREE, 0, 0, 32'hFFFF_FF7F));
        send_request(make_req(KIND_ALLOC, 4096, 0, 32'd0));
    endtask

    // The sink holds off for a long stretch while beats keep coming, so the
    // block fills up and has to drop tready on the input.
    task automatic test_output_stall();
        drain_results();
        sender_idle = 1'b0;
        hold_request = 300;
        for (int n = 0; n < 24; n++)
            send_request(make_random_request());
        drain_results();
    endtask

    // The sender pauses in the middle until every owed result is back.
    task automatic test_sender_pause();
        sender_idle = 1'b1;
        sink_idle = 1'b1;
        for (int n = 0; n < 12; n++)
            send_request(make_random_request());
        drain_results();
        for (int n = 0; n < 12; n++)
            send_request(make_random_request());
    endtask

    task automatic test_random_traffic();
        write_register(REG_BASE, 32'd0);
        write_register(REG_CAP, 32'(CAP_RESET));
        run_random_phase(150);
        write_register(REG_BASE, 32'hFFFF_FF81);
        write_register(REG_CAP, 32'h0000_1FFF);
        run_random_phase(150);
        write_register(REG_BASE, $urandom());
        write_register(REG_CAP, $urandom_range(600, 64));
        run_random_phase(130);
        write_register(REG_BASE, $urandom());
        write_register(REG_CAP, 32'(CAP_RESET));
        run_random_phase(130);
    endtask

    task automatic log_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %0s: expected %h, got %h at %0t", what, want, got, $realtime);
    endtask

    task automatic compare_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got)
            log_mismatch(what, want, got);
    endtask

    // Every result beat is compared with the oldest owed result. Sampling here
    // sees the values from before the edge, as the block's registers do.
    always @(posedge i_clk) begin : result_check
        t_alloc_resp want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_outcomes.size() == 0) begin
                log_mismatch("unexpected result beat", 32'd0, m_axis_tdata[31:0]);
            end else begin
                want = pending_outcomes.pop_front();
                compare_field("status", 32'(want.status), 32'(m_axis_tuser));
                compare_field("granted_address", want.granted, m_axis_tdata[31:0]);
                compare_field("used_bytes", 32'(want.used), 32'(m_axis_tdata[44:32]));
                compare_field("peak_bytes", 32'(want.peak), 32'(m_axis_tdata[57:45]));
            end
        end
    end

    // Result sink: random stalls, plus a long hold-off when one is requested,
    // counted down here cycle by cycle.
    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                stall_left = hold_request;
                hold_request = 0;
            end
            if (stall_left != 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (sink_idle && $urandom_range(3) == 0) begin
                m_axis_tready <= 1'b0;
                stall_left = pick_gap() - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #(20_000_000);
        $display("aligned_stack_allocator_core verification failed");
        $finish;
    end

    initial begin : test_sequence
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        model_base    = 32'd0;
        model_cap     = CAP_RESET;
        model_top     = 32'd0;
        model_peak    = 32'd0;
        for (int i = 0; i < REGION; i++)
            header_valid[i] = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_config();
        test_capacity_extremes();
        test_base_wrap();
        test_output_stall();
        test_sender_pause();
        test_random_traffic();

        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("aligned_stack_allocator_core verification clean");
        else
            $display("aligned_stack_allocator_core verification failed");
        $finish;
    end

endmodule
